// ===== design/urh_pkg.sv =====
// Shared types, opcodes and command codes for the undo/redo history stacks.
package urh_pkg;

    localparam int HISTORY_DEPTH = 256;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    localparam logic [2:0] OP_PUSH_INSERT  = 3'd0;
    localparam logic [2:0] OP_PUSH_DELETE  = 3'd1;
    localparam logic [2:0] OP_PUSH_NEWLINE = 3'd2;
    localparam logic [2:0] OP_UNDO         = 3'd3;
    localparam logic [2:0] OP_REDO         = 3'd4;
    localparam logic [2:0] OP_CLEAR        = 3'd5;

    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_DELETE  = 2'd1;
    localparam logic [1:0] KIND_NEWLINE = 2'd2;

    localparam logic [1:0] CMD_DELETE_BEFORE = 2'd0;
    localparam logic [1:0] CMD_INSERT_CHAR   = 2'd1;
    localparam logic [1:0] CMD_INSERT_BREAK  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  ch;
    } edit_rec_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_ctl_t;

endpackage

// ===== design/urh_cell.sv =====
// One stack slot: holds a record and shifts it to or from its neighbors.
module urh_cell
    import urh_pkg::*;
(
    input  logic       clk,
    input  stack_ctl_t ctl,
    input  edit_rec_t  above,
    input  edit_rec_t  below,
    output edit_rec_t  rec
);

    edit_rec_t rec_reg;

    // push moves records away from the top, pop moves them toward it
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            rec_reg <= above;
        end
        else if (ctl.pop)
        begin
            rec_reg <= below;
        end
    end

    assign rec = rec_reg;

endmodule

// ===== design/urh_stack.sv =====
// Bounded stack built as a chain of shifting cells with a depth counter.
module urh_stack
    import urh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  stack_ctl_t       ctl,
    input  edit_rec_t        push_rec,
    output edit_rec_t        top_rec,
    output logic [CNT_W-1:0] count
);

    edit_rec_t        recs [HISTORY_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    for (genvar i = 0; i < HISTORY_DEPTH; i++)
    begin : g_cell
        edit_rec_t above;
        edit_rec_t below;

        if (i == 0)
        begin : g_top
            assign above = push_rec;
        end
        else
        begin : g_mid
            assign above = recs[i-1];
        end

        if (i == HISTORY_DEPTH - 1)
        begin : g_bottom
            assign below = '0;
        end
        else
        begin : g_inner
            assign below = recs[i+1];
        end

        urh_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .above (above),
            .below (below),
            .rec   (recs[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top_rec = recs[0];
    assign count   = count_reg;

endmodule

// ===== design/undo_redo_history_stacks.sv =====
// Top level of the undo/redo history: two cell-chain stacks and the command logic.
//
// Input channel: opcode, row, col and char_in with in_valid / in_stall. Opcodes
// 0..2 record an insert, delete or newline; 3 undoes, 4 redoes, 5 clears both
// stacks; 6 and 7 do nothing. Every accepted item yields exactly one result item
// on the output channel (out_valid / out_stall): acted, edit_kind, cursor_row,
// cursor_col, char_out and the depths of both stacks after the step.
// The result is registered and is valid in the cycle after acceptance. Each stack
// is a chain of cells whose top cell is read directly, so an item updates both
// stacks in a single shift of the chain; with no stall, one item per cycle flows.
// When the receiver stalls, the result holds in the output register and
// in_stall rises, so no further item is taken until the result is taken; an
// item is accepted in the same cycle that the waiting result leaves.
// Configuration: cfg_write with cfg_data sets recording_enabled; write only
// while idle. When recording is off, push opcodes leave the stacks untouched.
// Reset (rst_n low, asynchronous): both depths go to zero, recording is
// enabled and the output register empties. The cells themselves need no
// clearing pass; only entries below a depth are ever read.
module undo_redo_history_stacks
    import urh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_write,
    input  logic             cfg_data,
    // input channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [2:0]       opcode,
    input  logic [15:0]      row,
    input  logic [15:0]      col,
    input  logic [7:0]       char_in,
    // output channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic             acted,
    output logic [1:0]       edit_kind,
    output logic [16:0]      cursor_row,
    output logic [16:0]      cursor_col,
    output logic [7:0]       char_out,
    output logic [CNT_W-1:0] undo_depth,
    output logic [CNT_W-1:0] redo_depth
);

    logic             recording_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             acted_reg;
    logic [1:0]       kind_reg;
    logic [16:0]      crow_reg;
    logic [16:0]      ccol_reg;
    logic [7:0]       char_reg;

    logic             acted_next;
    logic [1:0]       kind_next;
    logic [16:0]      crow_next;
    logic [16:0]      ccol_next;
    logic [7:0]       char_next;

    logic             accept;
    logic             is_push;
    logic             do_push;
    logic             undo_ok;
    logic             redo_ok;
    logic             hist_full;
    logic             hist_empty;
    logic             redo_full;
    logic             redo_empty;

    edit_rec_t        new_rec;
    edit_rec_t        hist_top;
    edit_rec_t        redo_top;
    edit_rec_t        hist_in;
    stack_ctl_t       hist_ctl;
    stack_ctl_t       redo_ctl;
    logic [CNT_W-1:0] hist_count;
    logic [CNT_W-1:0] redo_count;

    // Handshake: hold off new items only while a result waits on a stalled receiver
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Recording register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recording_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            recording_reg <= cfg_data;
        end
    end

    // Stack status
    assign hist_full  = (hist_count == CNT_W'(HISTORY_DEPTH));
    assign hist_empty = (hist_count == '0);
    assign redo_full  = (redo_count == CNT_W'(HISTORY_DEPTH));
    assign redo_empty = (redo_count == '0);

    // Decode the item
    assign is_push = (opcode == OP_PUSH_INSERT) || (opcode == OP_PUSH_DELETE)
                  || (opcode == OP_PUSH_NEWLINE);
    assign do_push = accept && is_push && recording_reg && !hist_full;
    assign undo_ok = accept && (opcode == OP_UNDO) && !hist_empty;
    assign redo_ok = accept && (opcode == OP_REDO) && !redo_empty;

    // Newline records carry no character
    assign new_rec.kind = opcode[1:0];
    assign new_rec.row  = row;
    assign new_rec.col  = col;
    assign new_rec.ch   = (opcode == OP_PUSH_NEWLINE) ? 8'd0 : char_in;

    // History takes new records or records coming back from redo; a record
    // that finds its target stack full is dropped
    assign hist_in        = do_push ? new_rec : redo_top;
    assign hist_ctl.push  = do_push || (redo_ok && !hist_full);
    assign hist_ctl.pop   = undo_ok;
    assign hist_ctl.clear = accept && (opcode == OP_CLEAR);

    // Any recorded edit wipes the redo stack
    assign redo_ctl.push  = undo_ok && !redo_full;
    assign redo_ctl.pop   = redo_ok;
    assign redo_ctl.clear = (accept && (opcode == OP_CLEAR)) || do_push;

    urh_stack u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (hist_ctl),
        .push_rec (hist_in),
        .top_rec  (hist_top),
        .count    (hist_count)
    );

    urh_stack u_redo (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (redo_ctl),
        .push_rec (hist_top),
        .top_rec  (redo_top),
        .count    (redo_count)
    );

    // Edit command: undo issues the inverse of the record, redo the edit itself.
    // Fields stay zero when nothing is popped.
    always_comb
    begin
        acted_next = 1'b0;
        kind_next  = CMD_DELETE_BEFORE;
        crow_next  = '0;
        ccol_next  = '0;
        char_next  = '0;
        if (undo_ok)
        begin
            acted_next = 1'b1;
            unique case (hist_top.kind)
                KIND_INSERT:
                begin
                    kind_next = CMD_DELETE_BEFORE;
                    crow_next = {1'b0, hist_top.row};
                    ccol_next = {1'b0, hist_top.col} + 17'd1;
                end
                KIND_DELETE:
                begin
                    kind_next = CMD_INSERT_CHAR;
                    crow_next = {1'b0, hist_top.row};
                    ccol_next = {1'b0, hist_top.col};
                    char_next = hist_top.ch;
                end
                default:
                begin
                    kind_next = CMD_DELETE_BEFORE;
                    crow_next = {1'b0, hist_top.row} + 17'd1;
                end
            endcase
        end
        else if (redo_ok)
        begin
            acted_next = 1'b1;
            unique case (redo_top.kind)
                KIND_INSERT:
                begin
                    kind_next = CMD_INSERT_CHAR;
                    crow_next = {1'b0, redo_top.row};
                    ccol_next = {1'b0, redo_top.col};
                    char_next = redo_top.ch;
                end
                KIND_DELETE:
                begin
                    kind_next = CMD_DELETE_BEFORE;
                    crow_next = {1'b0, redo_top.row};
                    ccol_next = {1'b0, redo_top.col} + 17'd1;
                end
                default:
                begin
                    kind_next = CMD_INSERT_BREAK;
                    crow_next = {1'b0, redo_top.row};
                    ccol_next = {1'b0, redo_top.col};
                end
            endcase
        end
    end

    // Output register: load on accept, drop once taken, hold while stalled
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acted_reg <= acted_next;
            kind_reg  <= kind_next;
            crow_reg  <= crow_next;
            ccol_reg  <= ccol_next;
            char_reg  <= char_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign acted      = acted_reg;
    assign edit_kind  = kind_reg;
    assign cursor_row = crow_reg;
    assign cursor_col = ccol_reg;
    assign char_out   = char_reg;
    // Counts only move on accept, so they match the held result
    assign undo_depth = hist_count;
    assign redo_depth = redo_count;

    // Depths never exceed the stack size
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (hist_count <= CNT_W'(HISTORY_DEPTH)) && (redo_count <= CNT_W'(HISTORY_DEPTH)))
        else $error("stack depth beyond capacity");

    // A recorded edit leaves the redo stack empty
    a_push_clears_redo: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> (redo_depth == '0))
        else $error("redo stack not cleared by recorded edit");

    // A result without a command carries all-zero command fields
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !acted) |-> ((edit_kind == CMD_DELETE_BEFORE) && (cursor_row == '0)
                                   && (cursor_col == '0) && (char_out == '0)))
        else $error("non-zero command fields without action");

    // Only an insert-character command carries a character
    a_char_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (edit_kind != CMD_INSERT_CHAR)) |-> (char_out == '0))
        else $error("character on a command that takes none");

endmodule
